// ===== hdl/plm_pkg.sv =====
// plm_pkg: shared constants, command and status codes, cell control type
// and word conversion functions for the positional list engine
// no dependencies
`default_nettype none

package plm_pkg;

    localparam int DEPTH      = 32;
    localparam int DATA_WIDTH = 32;
    localparam int MAX_OUT    = 32;
    localparam int OUT_CAP    = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_READ    = 3'd0;
    localparam logic [2:0] CMD_INS_HD  = 3'd1;
    localparam logic [2:0] CMD_INS_TL  = 3'd2;
    localparam logic [2:0] CMD_INS_POS = 3'd3;
    localparam logic [2:0] CMD_DEL_HD  = 3'd4;
    localparam logic [2:0] CMD_DEL_TL  = 3'd5;
    localparam logic [2:0] CMD_DEL_POS = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_WRONG = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    // idx: insert/delete slot, or last occupied slot for a rotate
    // data: word to insert, or head word for a rotate
    typedef struct packed {
        logic [1:0]            op;
        logic [IDX_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] data;
    } cell_ctrl_t;

    function automatic logic [DATA_WIDTH-1:0] to_cell(input logic [31:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [31:0] to_element(input logic [DATA_WIDTH-1:0] d);
        logic signed [63:0] w;
        w = 64'(signed'(d));
        return w[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/plm_cell.sv =====
// plm_cell: one storage slot of the list chain
// takes its word from itself, its left or right neighbor, or the broadcast word
// depends on plm_pkg
`default_nettype none

module plm_cell
(
    input  wire logic                              clk,
    input  wire plm_pkg::cell_ctrl_t               ctrl,
    input  wire logic [plm_pkg::IDX_W-1:0]         cell_index,
    input  wire logic [plm_pkg::DATA_WIDTH-1:0]    prev_data,
    input  wire logic [plm_pkg::DATA_WIDTH-1:0]    next_data,
    output logic      [plm_pkg::DATA_WIDTH-1:0]    data
);

    logic [plm_pkg::DATA_WIDTH-1:0] data_reg;
    logic [plm_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            plm_pkg::OP_HOLD:
            begin
                data_next = data_reg;
            end
            plm_pkg::OP_INS:
            begin
                if (cell_index > ctrl.idx)
                begin
                    data_next = prev_data;
                end
                else if (cell_index == ctrl.idx)
                begin
                    data_next = ctrl.data;
                end
            end
            plm_pkg::OP_DEL:
            begin
                if (cell_index >= ctrl.idx)
                begin
                    data_next = next_data;
                end
            end
            plm_pkg::OP_ROT:
            begin
                if (cell_index < ctrl.idx)
                begin
                    data_next = next_data;
                end
                else if (cell_index == ctrl.idx)
                begin
                    data_next = ctrl.data;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== hdl/positional_list_engine.sv =====
// positional_list_engine: bounded ordered list held in a shifting chain of cells
// update commands: request taken in one cycle, executed the next, result
// registered from the execute step; a new request is taken only once busy drops
// read out: busy through the execute step and the read out, one element per cycle
// from the head cell as the chain rotates through itself; rst_n (async) empties
// the list; results cannot be stalled; depends on plm_pkg and plm_cell
`default_nettype none

module positional_list_engine
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  cmd,
    input  wire logic [31:0] value,
    input  wire logic [7:0]  position,
    output logic             strobe,
    output logic [31:0]      element,
    output logic [1:0]       status,
    output logic             last,
    output logic [5:0]       length
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    localparam int CW = plm_pkg::CNT_W;
    localparam int IW = plm_pkg::IDX_W;

    logic [1:0]    state_reg, state_next;
    logic [2:0]    cmd_reg;
    logic [31:0]   value_reg;
    logic [7:0]    pos_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_reg, rd_next;

    logic          strobe_reg, strobe_next;
    logic [31:0]   element_reg, element_next;
    logic [1:0]    status_reg, status_next;
    logic          last_reg, last_next;
    logic [5:0]    length_reg, length_next;

    plm_pkg::cell_ctrl_t ctrl;
    logic [plm_pkg::DATA_WIDTH-1:0] cell_q [plm_pkg::DEPTH];

    logic          full;
    logic [8:0]    pos_w;
    logic [8:0]    cnt_w;
    logic [CW-1:0] out_n;

    assign full  = (count_reg >= CW'(plm_pkg::DEPTH));
    assign pos_w = {1'b0, pos_reg};
    assign cnt_w = 9'(count_reg);
    assign out_n = (count_reg > CW'(plm_pkg::OUT_CAP)) ? CW'(plm_pkg::OUT_CAP) : count_reg;

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < plm_pkg::DEPTH; gi++)
        begin : g_cell
            logic [plm_pkg::DATA_WIDTH-1:0] prev_d;
            logic [plm_pkg::DATA_WIDTH-1:0] next_d;
            if (gi == 0)
            begin : g_first
                assign prev_d = cell_q[gi];
            end
            else
            begin : g_mid_prev
                assign prev_d = cell_q[gi-1];
            end
            if (gi == plm_pkg::DEPTH - 1)
            begin : g_tail
                assign next_d = cell_q[gi];
            end
            else
            begin : g_mid_next
                assign next_d = cell_q[gi+1];
            end
            plm_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .cell_index (IW'(gi)),
                .prev_data  (prev_d),
                .next_data  (next_d),
                .data       (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_next      = rd_reg;
        strobe_next  = 1'b0;
        element_next = element_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        length_next  = length_reg;
        ctrl.op      = plm_pkg::OP_HOLD;
        ctrl.idx     = '0;
        ctrl.data    = plm_pkg::to_cell(value_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next   = S_IDLE;
                strobe_next  = 1'b1;
                element_next = '0;
                status_next  = plm_pkg::ST_OK;
                last_next    = 1'b1;
                unique case (cmd_reg)
                    plm_pkg::CMD_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = plm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            strobe_next = 1'b0;
                            state_next  = S_READ;
                            rd_next     = '0;
                        end
                    end
                    plm_pkg::CMD_INS_HD, plm_pkg::CMD_INS_TL, plm_pkg::CMD_INS_POS:
                    begin
                        if (full)
                        begin
                            status_next = plm_pkg::ST_FULL;
                        end
                        else if (cmd_reg == plm_pkg::CMD_INS_HD)
                        begin
                            ctrl.op    = plm_pkg::OP_INS;
                            ctrl.idx   = '0;
                            count_next = count_reg + 1'b1;
                        end
                        else if (cmd_reg == plm_pkg::CMD_INS_TL)
                        begin
                            ctrl.op    = plm_pkg::OP_INS;
                            ctrl.idx   = IW'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                        else if (pos_reg != 8'd0 && pos_w <= cnt_w + 9'd1)
                        begin
                            ctrl.op    = plm_pkg::OP_INS;
                            ctrl.idx   = IW'(pos_reg - 8'd1);
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            status_next = plm_pkg::ST_WRONG;
                        end
                    end
                    plm_pkg::CMD_DEL_HD, plm_pkg::CMD_DEL_TL:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = plm_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op    = plm_pkg::OP_DEL;
                            ctrl.idx   = (cmd_reg == plm_pkg::CMD_DEL_HD) ? '0
                                       : IW'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                        end
                    end
                    plm_pkg::CMD_DEL_POS:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = (pos_reg == 8'd1) ? plm_pkg::ST_EMPTY
                                        : plm_pkg::ST_WRONG;
                        end
                        else if (pos_reg != 8'd0 && pos_w <= cnt_w)
                        begin
                            ctrl.op    = plm_pkg::OP_DEL;
                            ctrl.idx   = IW'(pos_reg - 8'd1);
                            count_next = count_reg - 1'b1;
                        end
                        else
                        begin
                            status_next = plm_pkg::ST_WRONG;
                        end
                    end
                    default:
                    begin
                        status_next = plm_pkg::ST_WRONG;
                    end
                endcase
                length_next = 6'(count_next);
            end
            S_READ:
            begin
                // rotate the occupied cells left by one, head wraps to the tail
                ctrl.op      = plm_pkg::OP_ROT;
                ctrl.idx     = IW'(count_reg - 1'b1);
                ctrl.data    = cell_q[0];
                strobe_next  = (rd_reg < CW'(plm_pkg::OUT_CAP));
                element_next = plm_pkg::to_element(cell_q[0]);
                status_next  = plm_pkg::ST_OK;
                last_next    = (rd_reg == out_n - 1'b1);
                length_next  = 6'(count_reg);
                rd_next      = rd_reg + 1'b1;
                if (rd_reg == count_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            rd_reg     <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_reg     <= rd_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
            pos_reg   <= position;
        end
        element_reg <= element_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
        length_reg  <= length_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign strobe  = strobe_reg;
    assign element = element_reg;
    assign status  = status_reg;
    assign last    = last_reg;
    assign length  = length_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(plm_pkg::DEPTH))
        else $error("element count above depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1
                  || count_reg == $past(count_reg) - 1'b1))
        else $error("element count moved by more than one");

    a_count_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> count_reg == $past(count_reg))
        else $error("element count changed during read out");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && last_reg |=> !strobe_reg)
        else $error("result directly after final result");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && status_reg != plm_pkg::ST_OK |-> last_reg)
        else $error("error status on a non-final result");
`endif

endmodule

`default_nettype wire
